/* hdl/hoi_pkg.sv */
// ----------------------------------------------------------------------------
// hoi_pkg
// Shared widths, constants, command/status types and the arctangent table
// used by the odometry integrator.
// ----------------------------------------------------------------------------
package hoi_pkg;

  localparam int PULSE_W   = 8;
  localparam int HEAD_W    = 13;
  localparam int DPP_W     = 16;
  localparam int POS_W     = 32;
  localparam int SUM_W     = PULSE_W + 1;
  localparam int TRAVEL_W  = SUM_W + DPP_W + 1;
  localparam int TRIG_W    = 32;
  localparam int Z_W       = 29;
  localparam int PROD_W    = TRAVEL_W + TRIG_W;
  localparam int DELTA_W   = PROD_W - 31;
  localparam int REM_W     = 11;
  localparam int ATAN_ENTRIES = 24;
  localparam int STEP_W    = $clog2(ATAN_ENTRIES);
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 80;

  localparam int TRIG_ITERATIONS_DEFAULT = 16;

  localparam logic [DPP_W-1:0]  DPP_RESET    = 16'd617;
  localparam logic [HEAD_W-1:0] FULL_TURN    = 13'd5760;
  localparam logic [HEAD_W-1:0] QUARTER_TURN = 13'd1440;
  localparam logic [HEAD_W-1:0] HALF_TURN    = 13'd2880;
  localparam logic [HEAD_W-1:0] THREE_QUARTER_TURN = 13'd4320;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic load;
    logic rotate;
    logic mul_x;
    logic mul_y;
    logic round;
    logic acc_x;
    logic acc_y;
    logic publish;
  } hoi_cmd_t;

  typedef struct packed {
    logic out_busy;
  } hoi_status_t;

  // atan(2^-i) in units of 2^-20 degree
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    unique case (idx)
      5'd0:    v = 29'sd47185920;
      5'd1:    v = 29'sd27855475;
      5'd2:    v = 29'sd14718068;
      5'd3:    v = 29'sd7471121;
      5'd4:    v = 29'sd3750058;
      5'd5:    v = 29'sd1876857;
      5'd6:    v = 29'sd938658;
      5'd7:    v = 29'sd469357;
      5'd8:    v = 29'sd234682;
      5'd9:    v = 29'sd117342;
      5'd10:   v = 29'sd58671;
      5'd11:   v = 29'sd29335;
      5'd12:   v = 29'sd14668;
      5'd13:   v = 29'sd7334;
      5'd14:   v = 29'sd3667;
      5'd15:   v = 29'sd1833;
      5'd16:   v = 29'sd917;
      5'd17:   v = 29'sd458;
      5'd18:   v = 29'sd229;
      5'd19:   v = 29'sd115;
      5'd20:   v = 29'sd57;
      5'd21:   v = 29'sd29;
      5'd22:   v = 29'sd14;
      5'd23:   v = 29'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/heading_odometry_integrator.sv */
// ----------------------------------------------------------------------------
// heading_odometry_integrator
// Dead-reckoning pose update from wheel pulse counts and an absolute heading.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one sample per transaction: left and right signed pulse
//   counts and a heading in 1/16 degree (wrapped once if a full turn or more)
//   cfg_* writes distance_per_pulse (Q0.16 metres); cfg_ready is always high,
//   write only while no sample is in flight
//   m_axis returns the updated X/Y position (Q16.16, saturating), the stored
//   heading and a saturation flag in tuser, one transaction per sample
//   a sample runs through load, the CORDIC loop (one step per cycle), the
//   shared multiplier for X then Y, the X and Y accumulators and the publish
//   state; s_axis_tready is high only in idle, so a new sample is taken only
//   once the last one has been handed to the output register
//   the output register holds a result while m_axis_tready is low; the next
//   sample is still taken and computed, and waits only for the hand-off
//   reset clears position and heading and sets distance_per_pulse to 617
// ----------------------------------------------------------------------------
module heading_odometry_integrator
  import hoi_pkg::*;
#(
  parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // left_pulse_delta[7:0], right_pulse_delta[15:8], heading_sixteenths[28:16]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [DPP_W-1:0]      cfg_data,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // x_position[31:0], y_position[63:32], heading_out[76:64]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // saturated[0]
  output logic                  m_axis_tuser
);

  hoi_cmd_t          cmd;
  hoi_status_t       status;
  logic [STEP_W-1:0] step;

  hoi_ctrl #(
    .TRIG_ITERATIONS(TRIG_ITERATIONS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd),
    .step          (step)
  );

  hoi_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .step          (step),
    .status        (status),
    .s_axis_tdata  (s_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

/* hdl/hoi_ctrl.sv */
// ----------------------------------------------------------------------------
// hoi_ctrl
// Sequencer for one odometry update: load, CORDIC steps, two multiplies,
// two accumulator updates and the hand-off to the output register.
// ----------------------------------------------------------------------------
module hoi_ctrl
  import hoi_pkg::*;
#(
  parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  hoi_status_t       status,
  output hoi_cmd_t          cmd,
  output logic [STEP_W-1:0] step
);

  localparam int STEPS = (TRIG_ITERATIONS < ATAN_ENTRIES) ? TRIG_ITERATIONS : ATAN_ENTRIES;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ROTATE  = 3'd1;
  localparam logic [2:0] S_MUL_X   = 3'd2;
  localparam logic [2:0] S_MUL_Y   = 3'd3;
  localparam logic [2:0] S_ACC_X   = 3'd4;
  localparam logic [2:0] S_ACC_Y   = 3'd5;
  localparam logic [2:0] S_PUBLISH = 3'd6;

  logic [2:0]        state, state_next;
  logic [STEP_W-1:0] step_next;

  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.load   = 1'b1;
          step_next  = '0;
          state_next = S_ROTATE;
        end
      end
      S_ROTATE: begin
        cmd.rotate = 1'b1;
        if (step == LAST_STEP) begin
          state_next = S_MUL_X;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_MUL_X: begin
        cmd.mul_x  = 1'b1;
        state_next = S_MUL_Y;
      end
      S_MUL_Y: begin
        cmd.mul_y  = 1'b1;
        cmd.round  = 1'b1;
        state_next = S_ACC_X;
      end
      S_ACC_X: begin
        cmd.acc_x  = 1'b1;
        cmd.round  = 1'b1;
        state_next = S_ACC_Y;
      end
      S_ACC_Y: begin
        cmd.acc_y  = 1'b1;
        state_next = S_PUBLISH;
      end
      S_PUBLISH: begin
        // hold until the output register can take the result
        if (!status.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

/* hdl/hoi_datapath.sv */
// ----------------------------------------------------------------------------
// hoi_datapath
// Travel product, heading wrap and quadrant split, CORDIC rotation, shared
// multiplier, saturating accumulators, config register and output register.
// ----------------------------------------------------------------------------
module hoi_datapath
  import hoi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  hoi_cmd_t              cmd,
  input  logic [STEP_W-1:0]     step,
  output hoi_status_t           status,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [DPP_W-1:0]      cfg_data,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser
);

  logic [DPP_W-1:0]            dpp;
  logic signed [TRAVEL_W-1:0]  travel;
  logic [HEAD_W-1:0]           heading;
  logic [1:0]                  quad;
  logic signed [TRIG_W-1:0]    cx, cy;
  logic signed [Z_W-1:0]       cz;
  logic signed [PROD_W-1:0]    prod;
  logic signed [DELTA_W-1:0]   delta;
  logic signed [POS_W-1:0]     acc_x, acc_y;
  logic                        clip;

  logic signed [PULSE_W-1:0]   left_pulse_delta, right_pulse_delta;
  logic [HEAD_W-1:0]           heading_sixteenths;
  logic signed [SUM_W-1:0]     pulse_sum;
  logic [HEAD_W-1:0]           head_wrap, quad_base;
  logic [1:0]                  quad_in;
  logic [REM_W-1:0]            remainder;
  logic signed [TRIG_W-1:0]    cx_sh, cy_sh, cos_v, sin_v, mul_op;
  logic signed [PROD_W-1:0]    prod_round;
  logic signed [POS_W-1:0]     acc_sel, acc_sat;
  logic signed [POS_W:0]       acc_sum;
  logic                        acc_ovf;

  assign cfg_ready = 1'b1;
  assign status.out_busy = m_axis_tvalid && !m_axis_tready;

  assign left_pulse_delta   = s_axis_tdata[7:0];
  assign right_pulse_delta  = s_axis_tdata[15:8];
  assign heading_sixteenths = s_axis_tdata[28:16];
  assign pulse_sum = SUM_W'(left_pulse_delta) + SUM_W'(right_pulse_delta);

  // headings of one full turn and above wrap once
  always_comb begin
    head_wrap = (heading_sixteenths >= FULL_TURN) ? heading_sixteenths - FULL_TURN
                                                  : heading_sixteenths;
    priority if (head_wrap >= THREE_QUARTER_TURN) begin
      quad_in = QUAD_3;  quad_base = THREE_QUARTER_TURN;
    end else if (head_wrap >= HALF_TURN) begin
      quad_in = QUAD_2;  quad_base = HALF_TURN;
    end else if (head_wrap >= QUARTER_TURN) begin
      quad_in = QUAD_1;  quad_base = QUARTER_TURN;
    end else begin
      quad_in = QUAD_0;  quad_base = '0;
    end
    remainder = REM_W'(head_wrap - quad_base);
  end

  assign cx_sh = cx >>> step;
  assign cy_sh = cy >>> step;

  // map the first-quadrant pair onto the full circle
  always_comb begin
    unique case (quad)
      QUAD_0: begin cos_v = cx;  sin_v = cy;  end
      QUAD_1: begin cos_v = -cy; sin_v = cx;  end
      QUAD_2: begin cos_v = -cx; sin_v = -cy; end
      QUAD_3: begin cos_v = cy;  sin_v = -cx; end
      default: begin cos_v = cx; sin_v = cy;  end
    endcase
  end

  assign mul_op     = cmd.mul_y ? sin_v : cos_v;
  assign prod_round = prod + PROD_W'(64'sd1073741824);

  assign acc_sel = cmd.acc_y ? acc_y : acc_x;
  assign acc_sum = (POS_W+1)'(acc_sel) + (POS_W+1)'(delta);
  assign acc_ovf = acc_sum[POS_W] != acc_sum[POS_W-1];
  assign acc_sat = acc_ovf ? (acc_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                             : {1'b0, {(POS_W-1){1'b1}}})
                           : acc_sum[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dpp     <= DPP_RESET;
      acc_x   <= '0;
      acc_y   <= '0;
      heading <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dpp <= cfg_data;
      end
      if (cmd.load) begin
        heading <= head_wrap;
      end
      if (cmd.acc_x) begin
        acc_x <= acc_sat;
      end
      if (cmd.acc_y) begin
        acc_y <= acc_sat;
      end
      if (cmd.publish) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      travel <= pulse_sum * $signed({1'b0, dpp});
      quad   <= quad_in;
      cx     <= CORDIC_GAIN;
      cy     <= '0;
      cz     <= $signed(Z_W'({remainder, 16'd0}));
    end
    if (cmd.rotate) begin
      if (!cz[Z_W-1]) begin
        cx <= cx - cy_sh;
        cy <= cy + cx_sh;
        cz <= cz - atan_entry(step);
      end else begin
        cx <= cx + cy_sh;
        cy <= cy - cx_sh;
        cz <= cz + atan_entry(step);
      end
    end
    if (cmd.mul_x || cmd.mul_y) begin
      prod <= travel * mul_op;
    end
    if (cmd.round) begin
      delta <= DELTA_W'(prod_round >>> 31);
    end
    if (cmd.acc_x) begin
      clip <= acc_ovf;
    end else if (cmd.acc_y) begin
      clip <= clip | acc_ovf;
    end
    if (cmd.publish) begin
      m_axis_tdata <= {3'b000, heading, acc_y, acc_x};
      m_axis_tuser <= clip;
    end
  end

endmodule

/* tb/heading_odometry_integrator_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heading_odometry_integrator_tb
// Self-checking bench for the odometry integrator. Samples go in over the
// slave stream with random bursts and gaps, results are taken from the master
// stream under a changing back-pressure pattern and compared field by field
// with a local pose predictor (CORDIC, quadrant map, rounding, saturation).
// Directed samples cover the field extremes, the quadrant edges, heading wrap
// and zero distance; random phases then drive the pose to saturation both ways.
// ----------------------------------------------------------------------------
module heading_odometry_integrator_tb;
  import hoi_pkg::*;

  localparam int TRIG_STEPS   = TRIG_ITERATIONS_DEFAULT;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int TAIL_CYCLES  = 60;
  localparam int PRINT_LIMIT  = 40;

  // atan(2^-i) in 2^-20 degree
  localparam longint ATAN_DEG20 [ATAN_ENTRIES] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  typedef enum {MOVE_RANDOM, MOVE_FORWARD, MOVE_REVERSE} move_mode_t;
  typedef enum {READY_ALWAYS, READY_MOSTLY, READY_SELDOM, READY_PERIODIC} ready_mode_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic [HEAD_W-1:0]       heading;
    logic                    saturated;
  } pose_t;

  class odometry_scoreboard;
    logic [DPP_W-1:0]        dpp;
    logic signed [POS_W-1:0] x_acc;
    logic signed [POS_W-1:0] y_acc;
    pose_t                   expected_poses[$];
    int                      errors;
    int                      results_seen;

    function new();
      dpp = DPP_RESET;
      x_acc = '0;
      y_acc = '0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void report(string what, longint got, longint want);
      if (errors < PRINT_LIMIT)
        $display("[%0t] mismatch on result %0d, %s: got %0d expected %0d",
                 $time, results_seen, what, got, want);
      errors++;
    endfunction

    function logic signed [POS_W-1:0] clip_add(logic signed [POS_W-1:0] acc, longint d,
                                               inout logic clip);
      longint sum;
      sum = longint'(acc) + d;
      if (sum > 64'sd2147483647) begin
        clip = 1'b1;
        return 32'sh7fffffff;
      end
      if (sum < -64'sd2147483648) begin
        clip = 1'b1;
        return 32'sh80000000;
      end
      return sum[POS_W-1:0];
    endfunction

    // predicts the pose update of one accepted sample
    function void note_sample(logic signed [PULSE_W-1:0] left, logic signed [PULSE_W-1:0] right,
                              logic [HEAD_W-1:0] head_in);
      logic [HEAD_W-1:0] head;
      logic [1:0]        quad;
      longint            rem, travel, z, cx, cy, xs, ys, cv, sv, dx, dy;
      logic              clip;
      pose_t             p;
      head = head_in;
      if (head >= FULL_TURN)
        head = head - FULL_TURN;
      quad = 2'(head / QUARTER_TURN);
      rem = longint'(head) - longint'(quad) * longint'(QUARTER_TURN);
      travel = (longint'(left) + longint'(right)) * longint'(dpp);
      z = rem * 65536;
      cx = CORDIC_GAIN;
      cy = 0;
      for (int i = 0; i < TRIG_STEPS && i < ATAN_ENTRIES; i++) begin
        xs = cx >>> i;
        ys = cy >>> i;
        if (z >= 0) begin
          cx = cx - ys;
          cy = cy + xs;
          z = z - ATAN_DEG20[i];
        end else begin
          cx = cx + ys;
          cy = cy - xs;
          z = z + ATAN_DEG20[i];
        end
      end
      case (quad)
        QUAD_0: begin cv = cx;  sv = cy;  end
        QUAD_1: begin cv = -cy; sv = cx;  end
        QUAD_2: begin cv = -cx; sv = -cy; end
        default: begin cv = cy; sv = -cx; end
      endcase
      // Q16.16, rounded half up
      dx = (travel * cv + (64'sd1 <<< 30)) >>> 31;
      dy = (travel * sv + (64'sd1 <<< 30)) >>> 31;
      clip = 1'b0;
      x_acc = clip_add(x_acc, dx, clip);
      y_acc = clip_add(y_acc, dy, clip);
      p.x_pos = x_acc;
      p.y_pos = y_acc;
      p.heading = head;
      p.saturated = clip;
      expected_poses.push_back(p);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic user);
      pose_t want;
      if (expected_poses.size() == 0) begin
        report("result with no sample waiting", 0, 0);
        return;
      end
      want = expected_poses.pop_front();
      if (data[31:0] !== want.x_pos)
        report("x_position", $signed(data[31:0]), want.x_pos);
      if (data[63:32] !== want.y_pos)
        report("y_position", $signed(data[63:32]), want.y_pos);
      if (data[76:64] !== want.heading)
        report("heading_out", data[76:64], want.heading);
      if (user !== want.saturated)
        report("saturated", user, want.saturated);
      results_seen++;
    endfunction

    function int pending();
      return expected_poses.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [DPP_W-1:0]      cfg_data = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  odometry_scoreboard board;
  bit                 gaps_on = 1'b1;
  bit                 hold_request = 1'b0;
  int                 burst_left = 0;
  int                 idle_cycles = 0;
  logic [HEAD_W-1:0]  drive_heading;

  heading_odometry_integrator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // all driving tasks start and end at a falling edge
  task automatic send_sample(input logic signed [PULSE_W-1:0] left,
                             input logic signed [PULSE_W-1:0] right,
                             input logic [HEAD_W-1:0] head);
    s_axis_tdata <= {3'b000, head, right, left};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_sample(left, right, head);
    @(negedge clk);
  endtask

  task automatic offer(input logic signed [PULSE_W-1:0] left,
                       input logic signed [PULSE_W-1:0] right,
                       input logic [HEAD_W-1:0] head);
    int gap;
    if (burst_left == 0) begin
      if (gaps_on) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 25);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    send_sample(left, right, head);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  task automatic write_distance(input logic [DPP_W-1:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.dpp = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [PULSE_W-1:0] random_pulse();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 2))
        0: return -8'sd128;
        1: return 8'sd127;
        default: return 8'sd0;
      endcase
    end
    return PULSE_W'($urandom_range(0, 255));
  endfunction

  task automatic run_phase(input logic [DPP_W-1:0] dpp, input move_mode_t mode,
                           input int count, input bit gappy, input bit hold);
    logic signed [PULSE_W-1:0] left, right;
    logic [HEAD_W-1:0]         head;
    bit                        noise;
    wait_drained();
    write_distance(dpp);
    gaps_on = gappy;
    burst_left = 0;
    hold_request = hold;
    for (int n = 0; n < count; n++) begin
      noise = (mode == MOVE_RANDOM) || ($urandom_range(0, 31) == 0);
      if (noise) begin
        left = random_pulse();
        right = random_pulse();
        head = ($urandom_range(0, 6) == 0) ? HEAD_W'($urandom_range(5760, 8191))
                                           : HEAD_W'($urandom_range(0, 5759));
      end else begin
        // steady run along one axis to push an accumulator into its limit
        if (mode == MOVE_FORWARD) begin
          left = PULSE_W'($urandom_range(104, 127));
          right = PULSE_W'($urandom_range(104, 127));
        end else begin
          left = -PULSE_W'($urandom_range(104, 128));
          right = -PULSE_W'($urandom_range(104, 128));
        end
        head = drive_heading + HEAD_W'($urandom_range(0, 40));
      end
      offer(left, right, head);
    end
  endtask

  // receiver back-pressure, plus one long hold-off on request
  initial begin
    ready_mode_t mode;
    int          mode_left;
    int          tick;
    mode = READY_ALWAYS;
    mode_left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = ready_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(64, 256);
        end
        mode_left--;
        tick++;
        case (mode)
          READY_ALWAYS:  m_axis_tready <= 1'b1;
          READY_MOSTLY:  m_axis_tready <= ($urandom_range(0, 3) != 0);
          READY_SELDOM:  m_axis_tready <= ($urandom_range(0, 9) < 3);
          default:       m_axis_tready <= (tick % 5 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tdata, m_axis_tuser);
  end

  // ends the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("heading_odometry_integrator regression: fail");
        $finish;
      end
    end
  end

  initial begin
    board = new();
    drive_heading = HEAD_W'(QUARTER_TURN * $urandom_range(0, 3));
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset distance, field extremes, quadrant edges and heading wrap
    offer(0, 0, 0);
    offer(127, 127, 0);
    offer(-128, -128, 0);
    offer(127, -128, 1440);
    offer(-128, 127, 2880);
    offer(1, 0, 4320);
    offer(0, -1, 5759);
    offer(50, 50, 1439);
    offer(10, 20, 5760);
    offer(-7, 3, 8191);
    offer(100, 100, 719);
    offer(64, -64, 3000);
    offer(1, 1, 2159);
    offer(-1, -1, 7000);

    // zero distance still stores the heading
    wait_drained();
    write_distance(16'd0);
    offer(127, 127, 1000);
    offer(-128, -128, 6000);

    // largest distance with largest pulse sums
    wait_drained();
    write_distance(16'hffff);
    offer(127, 127, 0);
    offer(127, 127, 1440);
    offer(-128, -128, 2880);
    offer(-128, -128, 4320);
    offer(127, 127, 5759);
    offer(127, 127, 8191);
    offer(0, 0, 1440);

    run_phase(DPP_RESET, MOVE_RANDOM, 150, 1'b0, 1'b1);
    run_phase(16'hffff, MOVE_FORWARD, 360, 1'b1, 1'b0);
    run_phase(16'd0, MOVE_RANDOM, 120, 1'b1, 1'b0);
    run_phase(16'hffff, MOVE_REVERSE, 640, 1'b1, 1'b0);
    run_phase(DPP_W'($urandom_range(0, 65535)), MOVE_RANDOM, 180, 1'b1, 1'b0);
    run_phase(16'd1, MOVE_RANDOM, 150, 1'b1, 1'b0);

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (board.pending() != 0)
      board.report("samples left without a result", board.pending(), 0);
    if (board.errors == 0) begin
      $display("heading_odometry_integrator regression: pass");
    end else begin
      $display("heading_odometry_integrator regression: fail");
    end
    $finish;
  end

endmodule
